FILE: rtl/pairwise_snp_distance_counter_defines.svh
// assertion macros for the snp distance counter
`ifndef PAIRWISE_SNP_DISTANCE_COUNTER_DEFINES_SVH
`define PAIRWISE_SNP_DISTANCE_COUNTER_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define PSNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define PSNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PSNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/psnp_pkg.sv
package psnp_pkg;

  localparam int LANES       = 8;
  localparam int COUNT_WIDTH = 24;
  localparam int HIT_W       = $clog2(LANES + 1);
  localparam int SUM_W       = COUNT_WIDTH + 1;

  localparam int BYTE_W      = 8;
  localparam int BASES_W     = 64;
  localparam int CONS_W      = 24;
  localparam int CODE_W      = 3;
  localparam int USED_W      = 4;
  localparam int IN_DATA_W   = 160;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CODE_W-1:0] CODE_A = 3'd0;
  localparam logic [CODE_W-1:0] CODE_C = 3'd1;
  localparam logic [CODE_W-1:0] CODE_G = 3'd2;
  localparam logic [CODE_W-1:0] CODE_T = 3'd3;
  localparam logic [CODE_W-1:0] CODE_N = 3'd4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISTANCE_MODE = 1'b0,
    REG_COUNT_N       = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic distance_mode;
    logic count_n;
  } cfg_t;

  // one item after the lane compare
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [LANES-1:0] hits;
  } stage_t;

  function automatic logic [CODE_W-1:0] decode_base(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] code;
    case (b)
      8'h41, 8'h61: code = CODE_A;
      8'h43, 8'h63: code = CODE_C;
      8'h47, 8'h67: code = CODE_G;
      8'h54, 8'h74: code = CODE_T;
      default:      code = CODE_N;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/pairwise_snp_distance_counter.sv
// pairwise snp distance counter
// input stream (s_axis): one transaction carries up to eight aligned positions of two
// sequences, their consensus codes and a lane count; tlast marks the end of a pair.
// output stream (m_axis): one transaction per pair, sent after the transaction with
// tlast; tdata holds the count and tuser flags a count that stuck at its maximum.
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 distance mode,
// 1 count n positions); write only while no pair is in flight.
// throughput: one input transaction per cycle while s_axis_tready is high;
// eight lane comparators work in parallel and a single popcount-add updates
// the running count. the last transaction passes the lane compare register,
// then accumulates into the result register that drives m_axis.
// reset: running count, saturation flag and all valid bits clear; distance mode on,
// n counting off.
// stall: the result register holds while m_axis_tready is low; input keeps
// flowing until the next last transaction reaches the accumulator, then
// s_axis_tready drops until the pending result is taken.
`include "pairwise_snp_distance_counter_defines.svh"

module pairwise_snp_distance_counter
  import psnp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic                  cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // bases_first[63:0], bases_second[127:64], consensus_codes[151:128],
  // lanes_used[155:152], zero fill[159:156]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pair_count[23:0]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // count_saturated[0]
  output logic                  m_axis_tuser
);

  cfg_t                   cfg_q;
  stage_t                 stage_q, stage_d;
  logic [LANES-1:0]       hits;
  logic [BASES_W-1:0]     bases_first;
  logic [BASES_W-1:0]     bases_second;
  logic [CONS_W-1:0]      consensus_codes;
  logic [USED_W-1:0]      lanes_used;
  logic                   take;
  logic [COUNT_WIDTH-1:0] out_count;

  assign bases_first     = s_axis_tdata[63:0];
  assign bases_second    = s_axis_tdata[127:64];
  assign consensus_codes = s_axis_tdata[151:128];
  assign lanes_used      = s_axis_tdata[155:152];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.distance_mode <= 1'b1;
      cfg_q.count_n       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DISTANCE_MODE: cfg_q.distance_mode <= cfg_data_i;
        REG_COUNT_N:       cfg_q.count_n       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    psnp_lane u_lane (
      .byte_a_i (bases_first[l*BYTE_W +: BYTE_W]),
      .byte_b_i (bases_second[l*BYTE_W +: BYTE_W]),
      .cons_i   (consensus_codes[l*CODE_W +: CODE_W]),
      // lane counts above LANES enable every lane
      .en_i     (USED_W'(l) < lanes_used),
      .cfg_i    (cfg_q),
      .hit_o    (hits[l])
    );
  end

  assign s_axis_tready = !stage_q.valid || take;

  always_comb begin
    stage_d = stage_q;
    if (s_axis_tready) begin
      stage_d.valid = s_axis_tvalid;
      stage_d.last  = s_axis_tlast;
      stage_d.hits  = hits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  psnp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage_q),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (out_count),
    .out_sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_count);

  `PSNP_ASSERT_SAME(a_sat_means_max, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, out_count == COUNT_MAX, "saturated result without maximum count")
  `PSNP_ASSERT_SAME(a_last_waits, clk_i, rst_ni, stage_q.valid && stage_q.last && m_axis_tvalid && !m_axis_tready, !take && !s_axis_tready, "last transaction passed a pending result")
  `PSNP_ASSERT_NEXT(a_result_drains, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !(take && stage_q.last), !m_axis_tvalid, "result repeated after handshake")
  `PSNP_ASSERT_SAME(a_nonlast_flows, clk_i, rst_ni, stage_q.valid && !stage_q.last, take && s_axis_tready, "stall on a transaction that makes no result")

endmodule

FILE: rtl/psnp_lane.sv
module psnp_lane
  import psnp_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_a_i,
  input  logic [BYTE_W-1:0] byte_b_i,
  input  logic [CODE_W-1:0] cons_i,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  output logic              hit_o
);

  logic [CODE_W-1:0] code_a;
  logic [CODE_W-1:0] code_b;
  logic              dist_hit;
  logic              sim_hit;

  assign code_a = decode_base(byte_a_i);
  assign code_b = decode_base(byte_b_i);

  assign dist_hit = (code_a != code_b) &&
                    (cfg_i.count_n || ((code_a != CODE_N) && (code_b != CODE_N)));
  // consensus codes above n never equal a decoded base
  assign sim_hit  = (code_a == code_b) && (code_a != CODE_N) && (code_a != cons_i);

  assign hit_o = en_i && (cfg_i.distance_mode ? dist_hit : sim_hit);

endmodule

FILE: rtl/psnp_accum.sv
module psnp_accum
  import psnp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stage_t                 stage_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COUNT_WIDTH-1:0] out_count_o,
  output logic                   out_sat_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   sat_q, sat_d;
  logic                   out_valid_q, out_valid_d;
  logic [COUNT_WIDTH-1:0] out_count_q, out_count_d;
  logic                   out_sat_q, out_sat_d;
  logic [HIT_W-1:0]       popcnt;
  logic [SUM_W-1:0]       sum;
  logic                   ovf;
  logic [COUNT_WIDTH-1:0] clamped;
  logic                   out_free;

  always_comb begin
    popcnt = '0;
    for (int i = 0; i < LANES; i++) begin
      popcnt = popcnt + HIT_W'(stage_i.hits[i]);
    end
  end

  assign sum     = {1'b0, count_q} + SUM_W'(popcnt);
  assign ovf     = sum[COUNT_WIDTH];
  assign clamped = ovf ? COUNT_MAX : sum[COUNT_WIDTH-1:0];

  // only a last item has to wait for the result register
  assign out_free = !out_valid_q || out_ready_i;
  assign take_o   = stage_i.valid && (!stage_i.last || out_free);

  always_comb begin
    count_d     = count_q;
    sat_d       = sat_q;
    out_count_d = out_count_q;
    out_sat_d   = out_sat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take_o) begin
      if (stage_i.last) begin
        count_d     = '0;
        sat_d       = 1'b0;
        out_count_d = clamped;
        out_sat_d   = sat_q || ovf;
        out_valid_d = 1'b1;
      end else begin
        count_d = clamped;
        sat_d   = sat_q || ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
    out_sat_q   <= out_sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_sat_o   = out_sat_q;

endmodule
